@@ hw/rtl/gwp_pkg.sv @@
// ----------------------------------------------------------------------------
// G-code word parser package
// Character constants, letter and phase codes, and shared helper functions.
// ----------------------------------------------------------------------------
package gwp_pkg;

    // Parse phase codes
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_SPACE = 2'd1;
    localparam logic [1:0] PH_NUM   = 2'd2;

    // Word letter codes
    localparam logic [3:0] LTR_G    = 4'd0;
    localparam logic [3:0] LTR_M    = 4'd1;
    localparam logic [3:0] LTR_L    = 4'd2;
    localparam logic [3:0] LTR_X    = 4'd3;
    localparam logic [3:0] LTR_Y    = 4'd4;
    localparam logic [3:0] LTR_Z    = 4'd5;
    localparam logic [3:0] LTR_U    = 4'd6;
    localparam logic [3:0] LTR_V    = 4'd7;
    localparam logic [3:0] LTR_W    = 4'd8;
    localparam logic [3:0] LTR_I    = 4'd9;
    localparam logic [3:0] LTR_J    = 4'd10;
    localparam logic [3:0] LTR_K    = 4'd11;
    localparam logic [3:0] LTR_R    = 4'd12;
    localparam logic [3:0] LTR_P    = 4'd13;
    localparam logic [3:0] LTR_F    = 4'd14;
    localparam logic [3:0] LTR_NONE = 4'd15;

    // ASCII characters of interest
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CASE_BIT = 8'h20;

    // Flags of the number being read
    typedef struct packed {
        logic negative;
        logic seen_point;
        logic number_frozen;
    } t_num_flags;

    // Power of ten, used at elaboration only.
    function automatic longint unsigned pow10(input int n);
        longint unsigned r;
        r = 64'd1;
        for (int k = 0; k < n; k++) begin
            r = r * 64'd10;
        end
        return r;
    endfunction

    // Map a character, either case, to its word letter code.
    function automatic logic [3:0] letter_code(input logic [7:0] c);
        logic [7:0] lc;
        lc = c | CASE_BIT;
        case (lc)
            "g":     return LTR_G;
            "m":     return LTR_M;
            "l":     return LTR_L;
            "x":     return LTR_X;
            "y":     return LTR_Y;
            "z":     return LTR_Z;
            "u":     return LTR_U;
            "v":     return LTR_V;
            "w":     return LTR_W;
            "i":     return LTR_I;
            "j":     return LTR_J;
            "k":     return LTR_K;
            "r":     return LTR_R;
            "p":     return LTR_P;
            "f":     return LTR_F;
            default: return LTR_NONE;
        endcase
    endfunction

endpackage

@@ hw/rtl/gwp_char_if.sv @@
// ----------------------------------------------------------------------------
// Character channel
// Valid/ready channel that carries one program text character per transaction.
// ----------------------------------------------------------------------------
interface gwp_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       end_of_text;

    modport source (output valid, output ch, output end_of_text, input ready);
    modport sink   (input valid, input ch, input end_of_text, output ready);
endinterface

@@ hw/rtl/gwp_word_if.sv @@
// ----------------------------------------------------------------------------
// Word channel
// Valid/ready channel that carries one parsed word per transaction.
// ----------------------------------------------------------------------------
interface gwp_word_if #(
    parameter int VALUE_BITS = 36
);
    logic                         valid;
    logic                         ready;
    logic [3:0]                   word_letter;
    logic signed [VALUE_BITS-1:0] word_value;
    logic                         starts_block;
    logic                         axis_absolute;
    logic signed [VALUE_BITS-1:0] axis_position;
    logic signed [VALUE_BITS-1:0] start_x;
    logic signed [VALUE_BITS-1:0] start_y;
    logic signed [VALUE_BITS-1:0] start_z;
    logic                         last_result;

    modport source (
        output valid, output word_letter, output word_value, output starts_block,
        output axis_absolute, output axis_position, output start_x, output start_y,
        output start_z, output last_result, input ready
    );
    modport sink (
        input valid, input word_letter, input word_value, input starts_block,
        input axis_absolute, input axis_position, input start_x, input start_y,
        input start_z, input last_result, output ready
    );
endinterface

@@ hw/rtl/gwp_number.sv @@
// ----------------------------------------------------------------------------
// Number accumulator
// Next number state for one digit, point or minus character.
// ----------------------------------------------------------------------------
module gwp_number #(
    parameter int FRAC_DIGITS = 3,
    parameter int VALUE_BITS  = 36,
    parameter int FC_W        = 2
) (
    input  logic [7:0]              i_ch,
    input  logic                    i_in_space,
    input  gwp_pkg::t_num_flags     i_flags,
    input  logic [FC_W-1:0]         i_frac,
    input  logic [VALUE_BITS-1:0]   i_mag,
    output gwp_pkg::t_num_flags     o_flags,
    output logic [FC_W-1:0]         o_frac,
    output logic [VALUE_BITS-1:0]   o_mag
);
    import gwp_pkg::*;

    // Sums are formed wide enough that no carry is lost before saturation.
    localparam int SW = VALUE_BITS + 25;
    localparam logic [SW-1:0] CAP      = SW'(1) << (VALUE_BITS - 1);
    localparam logic [SW-1:0] TEN      = SW'(10);
    localparam logic [SW-1:0] INT_UNIT = SW'(pow10(FRAC_DIGITS));

    logic [SW-1:0] digit;
    logic [SW-1:0] weight;
    logic [SW-1:0] int_sum;
    logic [SW-1:0] frac_sum;

    // Digit weights: whole digits shift the value up one decade, fraction
    // digits add at the weight of their place.
    always_comb begin
        digit  = SW'(i_ch[3:0]);
        weight = '0;
        for (int k = 0; k < FRAC_DIGITS; k++) begin
            if (int'(i_frac) == k) begin
                weight = SW'(pow10(FRAC_DIGITS - 1 - k));
            end
        end
        int_sum  = SW'(i_mag) * TEN + digit * INT_UNIT;
        frac_sum = SW'(i_mag) + digit * weight;
    end

    // Character update of the number state.
    always_comb begin
        o_flags = i_flags;
        o_frac  = i_frac;
        o_mag   = i_mag;
        if (i_ch == CH_MINUS) begin
            if (i_in_space) begin
                o_flags.negative = 1'b1;
            end else begin
                o_flags.number_frozen = 1'b1;
            end
        end else if (i_ch == CH_POINT) begin
            if (i_flags.seen_point) begin
                o_flags.number_frozen = 1'b1;
            end else begin
                o_flags.seen_point = 1'b1;
            end
        end else if (!i_flags.number_frozen) begin
            if (!i_flags.seen_point) begin
                o_mag = (int_sum > CAP) ? CAP[VALUE_BITS-1:0] : int_sum[VALUE_BITS-1:0];
            end else if (int'(i_frac) < FRAC_DIGITS) begin
                o_mag  = (frac_sum > CAP) ? CAP[VALUE_BITS-1:0] : frac_sum[VALUE_BITS-1:0];
                o_frac = i_frac + 1'b1;
            end
        end
    end

endmodule

@@ hw/rtl/gwp_emit.sv @@
// ----------------------------------------------------------------------------
// Word emitter
// Signed word value with saturation, and the axis position update it causes.
// ----------------------------------------------------------------------------
module gwp_emit #(
    parameter int VALUE_BITS = 36
) (
    input  logic [3:0]                   i_letter,
    input  logic                         i_negative,
    input  logic [VALUE_BITS-1:0]        i_mag,
    input  logic signed [VALUE_BITS-1:0] i_pos_x,
    input  logic signed [VALUE_BITS-1:0] i_pos_y,
    input  logic signed [VALUE_BITS-1:0] i_pos_z,
    output logic signed [VALUE_BITS-1:0] o_value,
    output logic signed [VALUE_BITS-1:0] o_axis_position,
    output logic signed [VALUE_BITS-1:0] o_pos_x,
    output logic signed [VALUE_BITS-1:0] o_pos_y,
    output logic signed [VALUE_BITS-1:0] o_pos_z
);
    import gwp_pkg::*;

    localparam logic [VALUE_BITS-1:0] VMAX = {1'b0, {(VALUE_BITS - 1){1'b1}}};
    localparam logic [VALUE_BITS-1:0] VMIN = {1'b1, {(VALUE_BITS - 1){1'b0}}};

    logic signed [VALUE_BITS-1:0] base;
    logic signed [VALUE_BITS-1:0] sum;
    logic signed [VALUE_BITS-1:0] sat_sum;

    // The magnitude never exceeds the cap, so the negated cap is the minimum.
    always_comb begin
        if (i_negative) begin
            o_value = -$signed(i_mag);
        end else if (i_mag[VALUE_BITS-1]) begin
            o_value = $signed(VMAX);
        end else begin
            o_value = $signed(i_mag);
        end
    end

    // One saturating adder, shared by the relative axis words.
    always_comb begin
        unique case (i_letter)
            LTR_V:   base = i_pos_y;
            LTR_W:   base = i_pos_z;
            default: base = i_pos_x;
        endcase
        sum = base + o_value;
        if (base[VALUE_BITS-1] == o_value[VALUE_BITS-1] &&
            sum[VALUE_BITS-1] != base[VALUE_BITS-1]) begin
            sat_sum = o_value[VALUE_BITS-1] ? $signed(VMIN) : $signed(VMAX);
        end else begin
            sat_sum = sum;
        end
    end

    // Axis position update by word letter.
    always_comb begin
        o_pos_x         = i_pos_x;
        o_pos_y         = i_pos_y;
        o_pos_z         = i_pos_z;
        o_axis_position = '0;
        unique case (i_letter)
            LTR_X:   begin o_pos_x = o_value; o_axis_position = o_value; end
            LTR_Y:   begin o_pos_y = o_value; o_axis_position = o_value; end
            LTR_Z:   begin o_pos_z = o_value; o_axis_position = o_value; end
            LTR_U:   begin o_pos_x = sat_sum; o_axis_position = sat_sum; end
            LTR_V:   begin o_pos_y = sat_sum; o_axis_position = sat_sum; end
            LTR_W:   begin o_pos_z = sat_sum; o_axis_position = sat_sum; end
            default: begin end
        endcase
    end

endmodule

@@ hw/rtl/gwp_result_queue.sv @@
// ----------------------------------------------------------------------------
// Result queue
// Three-entry queue that takes up to two results per cycle and gives one.
// ----------------------------------------------------------------------------
module gwp_result_queue #(
    parameter int DW = 187
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [1:0]    i_push_cnt,
    input  logic [DW-1:0] i_data0,
    input  logic [DW-1:0] i_data1,
    input  logic          i_pop,
    output logic          o_room,
    output logic          o_valid,
    output logic [DW-1:0] o_data
);
    localparam int DEPTH = 3;

    logic [DW-1:0] r_q [DEPTH];
    logic [DW-1:0] n_q [DEPTH];
    logic [1:0]    r_cnt;
    logic [1:0]    n_cnt;
    logic [1:0]    base;

    // Input is taken only while two entries are free, so any character fits
    // whatever number of results it yields.
    assign o_room  = (r_cnt <= 2'd1);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_q[0];

    // Shift out the head on a pop, then write new results behind what is left.
    always_comb begin
        n_q[0] = i_pop ? r_q[1] : r_q[0];
        n_q[1] = i_pop ? r_q[2] : r_q[1];
        n_q[2] = r_q[2];
        base   = r_cnt - {1'b0, i_pop};
        for (int k = 0; k < DEPTH; k++) begin
            if (i_push_cnt != 2'd0 && 2'(k) == base) begin
                n_q[k] = i_data0;
            end
            if (i_push_cnt == 2'd2 && 2'(k) == base + 2'd1) begin
                n_q[k] = i_data1;
            end
        end
        n_cnt = base + i_push_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DEPTH; k++) begin
            r_q[k] <= n_q[k];
        end
    end

endmodule

@@ hw/rtl/gcode_word_parser.sv @@
// ----------------------------------------------------------------------------
// G-code word parser
// Cuts G-code text, one character per transaction, into block and field words,
// reads their numbers as saturated fixed point and tracks the axis positions.
// ----------------------------------------------------------------------------
// A word is written into the result queue when the character that ends it is
// accepted, and the output offers words from the registered head of the queue.
// One character per cycle while the queue has room; a character that yields two
// words fills a second queue entry, and the input then waits until the queue is
// back to at most one entry.
// Reset: synchronous, active low; clears the parse state, positions and queue.
// ----------------------------------------------------------------------------
module gcode_word_parser #(
    parameter int FRAC_DIGITS = 3,
    parameter int VALUE_BITS  = 36
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    gwp_char_if.sink         i_char,
    gwp_word_if.source       o_word
);
    import gwp_pkg::*;

    localparam int FC_W = (FRAC_DIGITS < 2) ? 1 : $clog2(FRAC_DIGITS + 1);
    localparam int VB   = VALUE_BITS;
    localparam int DW   = 7 + 5 * VB;

    // Parse state
    logic [1:0]           r_phase;
    logic                 r_in_block;
    logic [3:0]           r_letter;
    t_num_flags           r_flags;
    logic [FC_W-1:0]      r_frac;
    logic [VB-1:0]        r_mag;
    logic signed [VB-1:0] r_pos_x;
    logic signed [VB-1:0] r_pos_y;
    logic signed [VB-1:0] r_pos_z;

    logic                 accept;
    logic [7:0]           c;
    logic                 eot;
    logic                 is_num;
    logic                 active;
    logic                 consumed;
    logic                 emit_a;
    logic                 emit_b;
    logic [3:0]           code;
    logic                 is_blk;
    logic                 opens;

    t_num_flags           upd_flags;
    logic [FC_W-1:0]      upd_frac;
    logic [VB-1:0]        upd_mag;

    logic [1:0]           m_phase;
    logic [3:0]           m_letter;
    t_num_flags           m_flags;
    logic [FC_W-1:0]      m_frac;
    logic [VB-1:0]        m_mag;

    logic [3:0]           e_letter;
    logic                 e_negative;
    logic [VB-1:0]        e_mag;
    logic signed [VB-1:0] e_value;
    logic signed [VB-1:0] e_axis;
    logic signed [VB-1:0] e_pos_x;
    logic signed [VB-1:0] e_pos_y;
    logic signed [VB-1:0] e_pos_z;

    logic                 a_blk;
    logic                 b_blk;
    logic signed [VB-1:0] b_axis;
    logic [DW-1:0]        res_a;
    logic [DW-1:0]        res_b;
    logic [1:0]           push_cnt;
    logic                 q_room;
    logic                 q_valid;
    logic [DW-1:0]        q_data;

    assign accept = i_char.valid && i_char.ready;
    assign c      = i_char.ch;
    assign eot    = i_char.end_of_text;

    // Character classes and the decision whether the open word takes this character.
    assign is_num   = (c >= CH_ZERO && c <= CH_NINE) || c == CH_POINT || c == CH_MINUS;
    assign active   = (r_phase != PH_IDLE);
    assign consumed = active && ((r_phase == PH_SPACE && c == CH_SPACE) || is_num);
    assign emit_a   = active && !consumed;
    assign code     = letter_code(c);
    assign is_blk   = (code <= LTR_L);
    assign opens    = !consumed && (is_blk || (code != LTR_NONE && r_in_block));

    gwp_number #(
        .FRAC_DIGITS (FRAC_DIGITS),
        .VALUE_BITS  (VB),
        .FC_W        (FC_W)
    ) u_number (
        .i_ch       (c),
        .i_in_space (r_phase == PH_SPACE),
        .i_flags    (r_flags),
        .i_frac     (r_frac),
        .i_mag      (r_mag),
        .o_flags    (upd_flags),
        .o_frac     (upd_frac),
        .o_mag      (upd_mag)
    );

    // Word state after this character, before any end-of-text flush.
    always_comb begin
        m_phase  = PH_IDLE;
        m_letter = r_letter;
        m_flags  = '0;
        m_frac   = '0;
        m_mag    = '0;
        if (opens) begin
            m_phase  = PH_SPACE;
            m_letter = code;
        end else if (consumed && is_num) begin
            m_phase = PH_NUM;
            m_flags = upd_flags;
            m_frac  = upd_frac;
            m_mag   = upd_mag;
        end else if (consumed) begin
            m_phase = r_phase;
            m_flags = r_flags;
            m_frac  = r_frac;
            m_mag   = r_mag;
        end
    end

    assign emit_b = eot && (m_phase != PH_IDLE);

    // The emitter serves the word ended by this character, or else the flushed word.
    assign e_letter   = emit_a ? r_letter : m_letter;
    assign e_negative = emit_a ? r_flags.negative : m_flags.negative;
    assign e_mag      = emit_a ? r_mag : m_mag;

    gwp_emit #(
        .VALUE_BITS (VB)
    ) u_emit (
        .i_letter        (e_letter),
        .i_negative      (e_negative),
        .i_mag           (e_mag),
        .i_pos_x         (r_pos_x),
        .i_pos_y         (r_pos_y),
        .i_pos_z         (r_pos_z),
        .o_value         (e_value),
        .o_axis_position (e_axis),
        .o_pos_x         (e_pos_x),
        .o_pos_y         (e_pos_y),
        .o_pos_z         (e_pos_z)
    );

    // A second word in one transaction is always a fresh word with an empty number.
    assign a_blk = (e_letter <= LTR_L);
    assign b_blk = (m_letter <= LTR_L);

    always_comb begin
        unique case (m_letter)
            LTR_U:   b_axis = e_pos_x;
            LTR_V:   b_axis = e_pos_y;
            LTR_W:   b_axis = e_pos_z;
            default: b_axis = '0;
        endcase
    end

    assign res_a = {
        e_letter, e_value, a_blk,
        (e_letter >= LTR_X && e_letter <= LTR_Z), e_axis,
        a_blk ? e_pos_x : VB'(0), a_blk ? e_pos_y : VB'(0), a_blk ? e_pos_z : VB'(0),
        !(emit_a && emit_b)
    };
    assign res_b = {
        m_letter, VB'(0), b_blk,
        (m_letter >= LTR_X && m_letter <= LTR_Z), b_axis,
        b_blk ? e_pos_x : VB'(0), b_blk ? e_pos_y : VB'(0), b_blk ? e_pos_z : VB'(0),
        1'b1
    };

    assign push_cnt = accept ? {emit_a && emit_b, emit_a ^ emit_b} : 2'd0;

    // Parse state update on each accepted transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accept && eot)) begin
            r_phase    <= PH_IDLE;
            r_in_block <= 1'b0;
            r_letter   <= LTR_G;
            r_flags    <= '0;
            r_frac     <= '0;
            r_mag      <= '0;
            r_pos_x    <= '0;
            r_pos_y    <= '0;
            r_pos_z    <= '0;
        end else if (accept) begin
            r_phase    <= m_phase;
            r_in_block <= r_in_block || (opens && is_blk);
            r_letter   <= m_letter;
            r_flags    <= m_flags;
            r_frac     <= m_frac;
            r_mag      <= m_mag;
            if (emit_a) begin
                r_pos_x <= e_pos_x;
                r_pos_y <= e_pos_y;
                r_pos_z <= e_pos_z;
            end
        end
    end

    gwp_result_queue #(
        .DW (DW)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (push_cnt),
        .i_data0    (res_a),
        .i_data1    (res_b),
        .i_pop      (o_word.valid && o_word.ready),
        .o_room     (q_room),
        .o_valid    (q_valid),
        .o_data     (q_data)
    );

    // Output channel
    assign i_char.ready = q_room;
    assign o_word.valid = q_valid;
    assign {o_word.word_letter, o_word.word_value, o_word.starts_block,
            o_word.axis_absolute, o_word.axis_position, o_word.start_x,
            o_word.start_y, o_word.start_z, o_word.last_result} = q_data;

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// G-code word parser testbench
// Feeds program text one character per transaction, predicts every word
// and tracked position, and checks each word on the output in order.
// ----------------------------------------------------------------------------
module tb;
    import gwp_pkg::*;

    localparam int     VALUE_BITS     = 36;
    localparam int     FRAC_DIGITS    = 3;
    localparam longint VALUE_MAX      = (64'sd1 <<< (VALUE_BITS - 1)) - 1;
    localparam longint VALUE_MIN      = -VALUE_MAX - 1;
    localparam longint MAG_CAP        = VALUE_MAX + 1;
    localparam int     WATCHDOG_LIMIT = 1000;

    // One parsed word as it should appear on the output.
    typedef struct packed {
        logic [3:0]            letter;
        logic [VALUE_BITS-1:0] value;
        logic                  starts_block;
        logic                  axis_absolute;
        logic [VALUE_BITS-1:0] axis_position;
        logic [VALUE_BITS-1:0] start_x;
        logic [VALUE_BITS-1:0] start_y;
        logic [VALUE_BITS-1:0] start_z;
        logic                  last_result;
    } word_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    gwp_char_if                             char_bus ();
    gwp_word_if #(.VALUE_BITS(VALUE_BITS)) word_bus ();

    gcode_word_parser #(
        .FRAC_DIGITS (FRAC_DIGITS),
        .VALUE_BITS  (VALUE_BITS)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (char_bus),
        .o_word  (word_bus)
    );

    // Tokenizer state mirrored by the testbench.
    logic [1:0] tk_phase;
    logic       tk_in_block;
    logic [3:0] tk_letter;
    logic       tk_negative;
    logic       tk_point;
    logic       tk_frozen;
    int         tk_frac_count;
    longint     tk_magnitude;
    longint     tk_pos [3];

    word_t      expected_words [$];
    logic [7:0] text_buf [$];
    int         mismatch_count = 0;
    int         quiet_cycles = 0;
    bit         tx_throttle = 1'b0;
    bit         rx_throttle = 1'b0;
    int         tx_burst_left = 0;
    bit [15:0]  ready_pattern = '1;
    bit [5:0]   ready_phase = '0;

    // Clock generation.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Append one character to the end of the text buffer.
    function automatic void add_char(input logic [7:0] c);
        text_buf.insert(text_buf.size(), c);
    endfunction

    // Append one word to the end of the expected words.
    function automatic void add_expected(input word_t w);
        expected_words.insert(expected_words.size(), w);
    endfunction

    function automatic longint ten_to(input int n);
        longint r;
        r = 1;
        repeat (n) r = r * 10;
        return r;
    endfunction

    function automatic void clear_number();
        tk_negative   = 1'b0;
        tk_point      = 1'b0;
        tk_frozen     = 1'b0;
        tk_frac_count = 0;
        tk_magnitude  = 0;
    endfunction

    function automatic void reset_tokenizer();
        tk_phase    = PH_IDLE;
        tk_in_block = 1'b0;
        tk_letter   = LTR_G;
        clear_number();
        foreach (tk_pos[k]) tk_pos[k] = 0;
    endfunction

    function automatic void open_word(input logic [3:0] code);
        tk_letter = code;
        tk_phase  = PH_SPACE;
        clear_number();
    endfunction

    // Close the pending word, update the tracked axes and queue the result.
    function automatic void finish_word();
        longint value;
        longint sum;
        int     axis;
        word_t  w;
        if (tk_negative) begin
            value = (tk_magnitude >= MAG_CAP) ? VALUE_MIN : -tk_magnitude;
        end else begin
            value = (tk_magnitude > VALUE_MAX) ? VALUE_MAX : tk_magnitude;
        end
        w = '0;
        w.letter       = tk_letter;
        w.value        = value[VALUE_BITS-1:0];
        w.starts_block = (tk_letter <= LTR_L);
        w.axis_absolute = (tk_letter >= LTR_X && tk_letter <= LTR_Z);
        if (tk_letter >= LTR_X && tk_letter <= LTR_Z) begin
            axis = int'(tk_letter) - int'(LTR_X);
            tk_pos[axis] = value;
            w.axis_position = tk_pos[axis][VALUE_BITS-1:0];
        end else if (tk_letter >= LTR_U && tk_letter <= LTR_W) begin
            // Relative moves add to the axis and clip at the value range.
            axis = int'(tk_letter) - int'(LTR_U);
            sum = tk_pos[axis] + value;
            if (sum > VALUE_MAX) sum = VALUE_MAX;
            if (sum < VALUE_MIN) sum = VALUE_MIN;
            tk_pos[axis] = sum;
            w.axis_position = tk_pos[axis][VALUE_BITS-1:0];
        end
        if (tk_letter <= LTR_L) begin
            w.start_x = tk_pos[0][VALUE_BITS-1:0];
            w.start_y = tk_pos[1][VALUE_BITS-1:0];
            w.start_z = tk_pos[2][VALUE_BITS-1:0];
        end
        add_expected(w);
        tk_phase = PH_IDLE;
        clear_number();
    endfunction

    // Advance the tokenizer by one accepted character.
    function automatic void tokenize_char(input logic [7:0] c, input logic last);
        string      letters;
        int         produced;
        logic       taken;
        logic [3:0] code;
        longint     digit;
        letters  = "gmlxyzuvwijkrpf";
        produced = 0;
        taken    = 1'b0;
        if (tk_phase != PH_IDLE) begin
            if (tk_phase == PH_SPACE && c == CH_SPACE) begin
                taken = 1'b1;
            end else if ((c >= CH_ZERO && c <= CH_NINE) || c == CH_POINT || c == CH_MINUS) begin
                taken = 1'b1;
                if (c == CH_MINUS) begin
                    // Only a minus right after the letter and spaces is a sign.
                    if (tk_phase == PH_SPACE) tk_negative = 1'b1;
                    else tk_frozen = 1'b1;
                end else if (c == CH_POINT) begin
                    if (tk_point) tk_frozen = 1'b1;
                    else tk_point = 1'b1;
                end else if (!tk_frozen) begin
                    digit = longint'(c - CH_ZERO);
                    if (!tk_point) begin
                        if (tk_magnitude > MAG_CAP / 10) begin
                            tk_magnitude = MAG_CAP;
                        end else begin
                            tk_magnitude = tk_magnitude * 10 + digit * ten_to(FRAC_DIGITS);
                        end
                    end else if (tk_frac_count < FRAC_DIGITS) begin
                        tk_magnitude = tk_magnitude
                                     + digit * ten_to(FRAC_DIGITS - 1 - tk_frac_count);
                        tk_frac_count++;
                    end
                    if (tk_magnitude > MAG_CAP) tk_magnitude = MAG_CAP;
                end
                tk_phase = PH_NUM;
            end else begin
                finish_word();
                produced++;
            end
        end
        // A character that was not part of a number may open a new word.
        if (!taken) begin
            code = LTR_NONE;
            for (int k = 0; k < letters.len(); k++) begin
                if ((c | CASE_BIT) == letters[k]) code = 4'(k);
            end
            if (code <= LTR_L) begin
                tk_in_block = 1'b1;
                open_word(code);
            end else if (code != LTR_NONE && tk_in_block) begin
                open_word(code);
            end
        end
        if (last) begin
            if (tk_phase != PH_IDLE) begin
                finish_word();
                produced++;
            end
            reset_tokenizer();
        end
        if (produced > 0) expected_words[expected_words.size() - 1].last_result = 1'b1;
    endfunction

    // Send one character, with random gaps between bursts when throttled.
    task automatic send_char(input logic [7:0] c, input logic last);
        int gap;
        if (tx_throttle && tx_burst_left == 0) begin
            gap = $urandom_range(0, 6);
            tx_burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                char_bus.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        if (tx_burst_left > 0) tx_burst_left--;
        char_bus.valid       <= 1'b1;
        char_bus.ch          <= c;
        char_bus.end_of_text <= last;
        @(posedge i_clk);
        while (!char_bus.ready) @(posedge i_clk);
        tokenize_char(c, last);
    endtask

    // Send the buffered text; its final character ends the text.
    task automatic send_text();
        for (int k = 0; k < text_buf.size(); k++) begin
            send_char(text_buf[k], k == text_buf.size() - 1);
        end
    endtask

    task automatic send_string(input string s);
        text_buf.delete();
        for (int k = 0; k < s.len(); k++) add_char(s[k]);
        send_text();
    endtask

    function automatic void append_digits(input int count);
        repeat (count) add_char(CH_ZERO + 8'($urandom_range(9)));
    endfunction

    // Random number text: mostly short, sometimes long enough to saturate,
    // now and then with a stray minus or point inside.
    function automatic void append_number();
        if ($urandom_range(3) == 0) add_char(CH_MINUS);
        append_digits(($urandom_range(9) == 0) ? $urandom_range(8, 12) : $urandom_range(0, 4));
        if ($urandom_range(2) == 0) begin
            add_char(CH_POINT);
            append_digits($urandom_range(0, 5));
        end
        if ($urandom_range(11) == 0) begin
            add_char($urandom_range(1) ? CH_MINUS : CH_POINT);
            append_digits($urandom_range(0, 3));
        end
    endfunction

    function automatic void append_word(input string letters);
        logic [7:0] c;
        c = letters[$urandom_range(letters.len() - 1)];
        add_char($urandom_range(1) ? (c | CASE_BIT) : c);
        if ($urandom_range(3) == 0) begin
            repeat ($urandom_range(1, 2)) add_char(CH_SPACE);
        end
        append_number();
    endfunction

    // Build a random program of one to four lines.
    function automatic void make_program();
        text_buf.delete();
        // A field word before any block is skipped by the parser.
        if ($urandom_range(4) == 0) append_word("XYZUVWIJKRPF");
        repeat ($urandom_range(1, 4)) begin
            append_word("GML");
            repeat ($urandom_range(0, 5)) begin
                repeat ($urandom_range(0, 2)) add_char(CH_SPACE);
                append_word(($urandom_range(7) == 0) ? "GML" : "XYZUVWIJKRPF");
            end
            if ($urandom_range(5) == 0) begin
                add_char("(");
                repeat ($urandom_range(1, 6)) add_char(8'($urandom_range(8'h20, 8'h7E)));
                add_char(")");
            end
            if ($urandom_range(3) != 0) add_char(8'h0A);
        end
        // End the text on one more block or axis word now and then.
        if ($urandom_range(3) == 0) append_word($urandom_range(1) ? "GML" : "XYZUVW");
    endfunction

    // Compare one field of a word and report a mismatch.
    task automatic compare_field(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    // Check every word transaction against the oldest expected word.
    always @(posedge i_clk) begin
        word_t want;
        word_t got;
        if (i_rst_n && word_bus.valid && word_bus.ready) begin
            got.letter        = word_bus.word_letter;
            got.value         = word_bus.word_value;
            got.starts_block  = word_bus.starts_block;
            got.axis_absolute = word_bus.axis_absolute;
            got.axis_position = word_bus.axis_position;
            got.start_x       = word_bus.start_x;
            got.start_y       = word_bus.start_y;
            got.start_z       = word_bus.start_z;
            got.last_result   = word_bus.last_result;
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual letter %0d value %0h",
                         $time, got.letter, got.value);
                mismatch_count++;
            end else begin
                want = expected_words.pop_front();
                compare_field("word_letter", 64'(want.letter), 64'(got.letter));
                compare_field("word_value", 64'(want.value), 64'(got.value));
                compare_field("starts_block", 64'(want.starts_block), 64'(got.starts_block));
                compare_field("axis_absolute", 64'(want.axis_absolute),
                              64'(got.axis_absolute));
                compare_field("axis_position", 64'(want.axis_position),
                              64'(got.axis_position));
                compare_field("start_x", 64'(want.start_x), 64'(got.start_x));
                compare_field("start_y", 64'(want.start_y), 64'(got.start_y));
                compare_field("start_z", 64'(want.start_z), 64'(got.start_z));
                compare_field("last_result", 64'(want.last_result), 64'(got.last_result));
            end
        end
    end

    // When throttled, output backpressure follows a rotating pattern that is redrawn often.
    always @(posedge i_clk) begin
        word_bus.ready <= ready_pattern[15] | !rx_throttle;
        if (ready_phase == 6'd47) begin
            ready_phase <= '0;
            case ($urandom_range(3))
                0:       ready_pattern <= '1;
                1:       ready_pattern <= 16'($urandom);
                2:       ready_pattern <= 16'($urandom | $urandom);
                default: ready_pattern <= 16'($urandom & $urandom) | 16'h8001;
            endcase
        end else begin
            ready_phase   <= ready_phase + 1'b1;
            ready_pattern <= {ready_pattern[14:0], ready_pattern[15]};
        end
    end

    // Count cycles in which neither channel moves a transaction.
    always @(posedge i_clk) begin
        if ((char_bus.valid && char_bus.ready) || (word_bus.valid && word_bus.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    // Sign, empty number, late minus and a word cut short by the next letter
    // at end of text, which yields two words for one character.
    task automatic test_word_boundaries();
        send_string("X5g -.5-3M");
    endtask

    // Saturation of values and of relative moves, truncated fraction digits,
    // and a second point that freezes the number.
    task automatic test_number_limits();
        send_string("l99999999z-99999999w-9.23456.7");
    endtask

    task automatic test_well_formed_programs(input int char_goal);
        int sent;
        sent = 0;
        while (sent < char_goal) begin
            make_program();
            sent += text_buf.size();
            send_text();
        end
    endtask

    // Raw bytes with random text ends, and programs cut off at random points.
    task automatic test_broken_text(input int char_goal);
        int sent;
        int cut;
        sent = 0;
        while (sent < char_goal) begin
            if ($urandom_range(1) == 0) begin
                repeat ($urandom_range(1, 8)) begin
                    send_char(8'($urandom_range(255)), $urandom_range(7) == 0);
                    sent++;
                end
            end else begin
                make_program();
                cut = $urandom_range(1, text_buf.size());
                while (text_buf.size() > cut) void'(text_buf.pop_back());
                sent += text_buf.size();
                send_text();
            end
        end
    endtask

    initial begin
        i_rst_n              <= 1'b0;
        char_bus.valid       <= 1'b0;
        char_bus.ch          <= '0;
        char_bus.end_of_text <= 1'b0;
        reset_tokenizer();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed text runs without throttling on either channel.
        test_word_boundaries();
        test_number_limits();

        tx_throttle = 1'b1;
        rx_throttle = 1'b1;
        test_well_formed_programs(1200);
        test_broken_text(300);

        @(posedge i_clk);
        char_bus.valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
